[src/fmbq_pkg.sv]
// fmbq_pkg: shared types and codes for the front/middle/back queue
// used by fmbq_cell and front_middle_back_queue; no dependencies
package fmbq_pkg;

	localparam int CAPACITY_DEFAULT   = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// operation codes carried in the mode field
	typedef enum logic [2:0] {
		MODE_PUSH_FRONT  = 3'd0,
		MODE_PUSH_MIDDLE = 3'd1,
		MODE_PUSH_BACK   = 3'd2,
		MODE_POP_FRONT   = 3'd3,
		MODE_POP_MIDDLE  = 3'd4,
		MODE_POP_BACK    = 3'd5,
		MODE_REVERSE     = 3'd6
	} fmbq_mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} fmbq_status_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] push_value;
	} fmbq_cmd_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} fmbq_rsp_t;

	// broadcast to every cell: insert opens a gap at pos, remove closes one
	typedef struct packed {
		logic ins;
		logic rem;
	} fmbq_cell_op_t;

endpackage

[src/fmbq_cell.sv]
// fmbq_cell: one storage cell of the queue chain
// shifts from its lower or upper neighbor, or loads the new word; uses fmbq_pkg
module fmbq_cell #(
	parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEFAULT,
	parameter int POS_WIDTH  = 4,
	parameter int INDEX      = 0
) (
	input  logic                    clk,
	input  fmbq_pkg::fmbq_cell_op_t op,
	input  logic [POS_WIDTH-1:0]    pos,
	input  logic [DATA_WIDTH-1:0]   load_word,
	input  logic [DATA_WIDTH-1:0]   lower_word,
	input  logic [DATA_WIDTH-1:0]   upper_word,
	output logic [DATA_WIDTH-1:0]   word_q
);
	import fmbq_pkg::*;

	localparam logic [POS_WIDTH-1:0] IDX = POS_WIDTH'(INDEX);

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (IDX > pos) begin
				word_q <= lower_word;
			end else if (IDX == pos) begin
				word_q <= load_word;
			end
		end else if (op.rem && IDX >= pos) begin
			word_q <= upper_word;
		end
	end

endmodule

[src/front_middle_back_queue.sv]
// front_middle_back_queue: top level of the front/middle/back queue
// a row of fmbq_cell instances plus count, orientation and result registers;
// uses fmbq_pkg
//
//   channel   handshake          payload   notes
//   command   start / busy       cmd       taken when start && !busy
//   result    done (strobe)      rsp       one word per command, one cycle
//
// one command per cycle: busy is always low, every command is finished in the
// cycle it is taken and its result shows on rsp with done in the next cycle.
// the same-cycle finish comes from all cells shifting at once toward or away from the
// insert/remove cell; the pop word is a read of one cell through a mux.
// reset clears the count, the orientation bit and done; cell contents are
// left as they are and only cells below the count are ever read.
// the receiver cannot stall: a result is there for exactly one cycle.
module front_middle_back_queue #(
	parameter int CAPACITY   = fmbq_pkg::CAPACITY_DEFAULT,
	parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fmbq_pkg::fmbq_cmd_t cmd,
	output logic                done,
	output fmbq_pkg::fmbq_rsp_t rsp
);
	import fmbq_pkg::*;

	localparam int POS_WIDTH = $clog2(CAPACITY);
	localparam int CNT_WIDTH = $clog2(CAPACITY + 1);
	localparam logic [CNT_WIDTH-1:0] CAP_CNT = CNT_WIDTH'(CAPACITY);
	localparam logic [CNT_WIDTH-1:0] ONE_CNT = CNT_WIDTH'(1);

	logic [CNT_WIDTH-1:0]  count_q;
	logic                  rev_q;
	logic                  done_q;
	fmbq_rsp_t             rsp_q;

	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
	logic [DATA_WIDTH-1:0] load_word;

	logic                  accept;
	logic                  is_full;
	logic                  is_empty;
	logic [CNT_WIDTH-1:0]  n_less1;
	logic [CNT_WIDTH-1:0]  half_ins;
	logic [CNT_WIDTH-1:0]  half_rem;
	logic [CNT_WIDTH-1:0]  ins_pos;
	logic [CNT_WIDTH-1:0]  rem_pos;
	logic [POS_WIDTH-1:0]  cell_pos;
	fmbq_cell_op_t         op;
	logic [CNT_WIDTH-1:0]  count_d;
	logic                  rev_d;
	logic [1:0]            status_d;
	logic [31:0]           popped_d;

	// every command finishes in the cycle it is taken
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign is_full  = (count_q >= CAP_CNT);
	assign is_empty = (count_q == '0);
	assign n_less1  = count_q - ONE_CNT;
	assign half_ins = count_q >> 1;
	assign half_rem = n_less1 >> 1;

	// stored word is the push value zero-extended or cut to the cell width
	assign load_word = DATA_WIDTH'($unsigned(cmd.push_value));

	// physical insert cell: logical index k maps to k, or n-k when reversed
	always_comb begin
		unique case (cmd.mode)
			MODE_PUSH_FRONT:  ins_pos = rev_q ? count_q : '0;
			MODE_PUSH_MIDDLE: ins_pos = rev_q ? (count_q - half_ins) : half_ins;
			default:          ins_pos = rev_q ? '0 : count_q;
		endcase
	end

	// physical remove cell: logical index k maps to k, or n-1-k when reversed
	always_comb begin
		unique case (cmd.mode)
			MODE_POP_FRONT:  rem_pos = rev_q ? n_less1 : '0;
			MODE_POP_MIDDLE: rem_pos = rev_q ? (n_less1 - half_rem) : half_rem;
			default:         rem_pos = rev_q ? '0 : n_less1;
		endcase
	end

	// command decode
	always_comb begin
		op       = '0;
		count_d  = count_q;
		rev_d    = rev_q;
		status_d = ST_OK;
		popped_d = '0;
		cell_pos = ins_pos[POS_WIDTH-1:0];
		unique case (cmd.mode) inside
			MODE_PUSH_FRONT, MODE_PUSH_MIDDLE, MODE_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op.ins  = accept;
					count_d = count_q + ONE_CNT;
				end
			end
			MODE_POP_FRONT, MODE_POP_MIDDLE, MODE_POP_BACK: begin
				cell_pos = rem_pos[POS_WIDTH-1:0];
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					op.rem   = accept;
					count_d  = n_less1;
					popped_d = 32'(cell_word[rem_pos[POS_WIDTH-1:0]]);
				end
			end
			MODE_REVERSE: begin
				rev_d = !rev_q;
			end
			default: begin
				// unused code: no change, status ok
			end
		endcase
	end

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower_word;
		logic [DATA_WIDTH-1:0] upper_word;

		// end cells never take from the missing neighbor
		if (i == 0) begin : g_low_end
			assign lower_word = cell_word[i];
		end else begin : g_low_mid
			assign lower_word = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_high_end
			assign upper_word = cell_word[i];
		end else begin : g_high_mid
			assign upper_word = cell_word[i+1];
		end

		fmbq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS_WIDTH  (POS_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (cell_pos),
			.load_word  (load_word),
			.lower_word (lower_word),
			.upper_word (upper_word),
			.word_q     (cell_word[i])
		);
	end

	// count, orientation and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rev_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
				rev_q   <= rev_d;
			end
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.popped_value <= popped_d;
			rsp_q.status       <= status_d;
			rsp_q.occupancy    <= 5'(count_d);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// every taken command gives exactly one result next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> done)
		else $error("command taken without a result strobe");

	// the count never goes past the number of cells
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CAP_CNT)
		else $error("queue count above capacity");

	// a dropped push leaves the count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && (cmd.mode == MODE_PUSH_FRONT || cmd.mode == MODE_PUSH_MIDDLE
			|| cmd.mode == MODE_PUSH_BACK)) |=> (count_q == $past(count_q)))
		else $error("push on full queue changed the count");

	// an error result never carries a popped word
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.popped_value == '0))
		else $error("error result with nonzero popped word");

endmodule

[test/tb.sv]
// tb: self-checking testbench for front_middle_back_queue
// a driver and a monitor as clocked blocks, with a queue-level predictor inline
// depends on fmbq_pkg and front_middle_back_queue from src
module tb;
	import fmbq_pkg::*;

	// the mode field has one code with no operation behind it
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int ITEM_TARGET = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	fmbq_cmd_t cmd = '0;
	logic busy;
	logic done;
	fmbq_rsp_t rsp;

	front_middle_back_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// commands still to be offered, and results still owed by the block
	fmbq_cmd_t cmd_backlog[$];
	fmbq_rsp_t pending_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;

	// predictor state: the words in storage order plus a flip bit, so a
	// reverse only toggles the bit and logical positions are mapped through it
	logic signed [31:0] held_words[$];
	logic flipped = 1'b0;

	// burst and gap bookkeeping for the sender
	int burst_left = 0;
	int gap_left = 0;

	// apply one command to the predictor and return the result it should give
	function automatic fmbq_rsp_t predict_queue_op(fmbq_cmd_t c);
		fmbq_rsp_t r;
		int n;
		int slot;
		n = held_words.size();
		r = '0;
		case (c.mode) inside
			MODE_PUSH_FRONT, MODE_PUSH_MIDDLE, MODE_PUSH_BACK: begin
				if (n >= CAPACITY_DEFAULT) begin
					r.status = ST_FULL;
				end else begin
					// logical insert position: front 0, middle n/2, back n
					if (c.mode == MODE_PUSH_FRONT) slot = 0;
					else if (c.mode == MODE_PUSH_MIDDLE) slot = n / 2;
					else slot = n;
					if (flipped) slot = n - slot;
					held_words.insert(slot, c.push_value);
				end
			end
			MODE_POP_FRONT, MODE_POP_MIDDLE, MODE_POP_BACK: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// logical remove position: front 0, middle (n-1)/2, back n-1
					if (c.mode == MODE_POP_FRONT) slot = 0;
					else if (c.mode == MODE_POP_MIDDLE) slot = (n - 1) / 2;
					else slot = n - 1;
					if (flipped) slot = n - 1 - slot;
					r.popped_value = held_words[slot];
					held_words.delete(slot);
				end
			end
			MODE_REVERSE: begin
				flipped = ~flipped;
			end
			default: begin
				// unused code: no change, plain ok result
			end
		endcase
		r.occupancy = 5'(held_words.size());
		return r;
	endfunction

	function automatic void queue_cmd(logic [2:0] m, logic [31:0] v);
		fmbq_cmd_t c;
		c.mode = m;
		c.push_value = v;
		cmd_backlog.push_back(c);
	endfunction

	// sender gaps: often none at all, so some bursts run back to back
	function automatic int pick_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
	endfunction

	// driver: a word is taken at an edge where start is high and busy low
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			burst_left = $urandom_range(1, 30);
			gap_left = 0;
		end else begin
			next_start = 1'b0;
			if (start && !busy) begin
				// word accepted: predict its result and retire it
				pending_results.push_back(predict_queue_op(cmd));
				void'(cmd_backlog.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = pick_gap();
				end
			end
			if (start && busy) begin
				// held off: keep offering the same word
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_backlog.size() > 0) begin
				next_start = 1'b1;
				cmd <= cmd_backlog[0];
			end
			start <= next_start;
		end
	end

	// monitor: each strobed result is checked against the oldest prediction
	always @(posedge clk) begin
		fmbq_rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: popped_value %0d status %0d occupancy %0d",
					rsp.popped_value, rsp.status, rsp.occupancy);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.popped_value !== want.popped_value) begin
					$error("popped_value: expected %0d, actual %0d",
						want.popped_value, rsp.popped_value);
					mismatch_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d",
						want.occupancy, rsp.occupancy);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// stimulus: directed words first, then random segments each with its own push bias
	initial begin
		int fill_bias;
		int seg_len;
		int roll;
		logic [31:0] val;
		logic [31:0] edge_vals[5];

		edge_vals[0] = 32'h8000_0000;
		edge_vals[1] = 32'h7fff_ffff;
		edge_vals[2] = 32'hffff_ffff;
		edge_vals[3] = 32'h0000_0000;
		edge_vals[4] = 32'h0000_0001;

		// pops and reverse on an empty queue, and the unused code
		queue_cmd(MODE_POP_FRONT, 32'h1234_5678);
		queue_cmd(MODE_POP_MIDDLE, 32'hffff_ffff);
		queue_cmd(MODE_POP_BACK, 32'h0);
		queue_cmd(MODE_REVERSE, 32'hdead_beef);
		queue_cmd(MODE_UNUSED, 32'hffff_ffff);
		// extreme words through every push kind
		queue_cmd(MODE_PUSH_BACK, 32'h8000_0000);
		queue_cmd(MODE_PUSH_FRONT, 32'h7fff_ffff);
		queue_cmd(MODE_PUSH_MIDDLE, 32'hffff_ffff);
		queue_cmd(MODE_PUSH_MIDDLE, 32'h0000_0000);
		queue_cmd(MODE_PUSH_BACK, 32'h0000_0001);
		// flipped orientation: every pop kind, then flip back
		queue_cmd(MODE_REVERSE, 32'h0);
		queue_cmd(MODE_POP_MIDDLE, 32'h0);
		queue_cmd(MODE_PUSH_FRONT, 32'h5555_5555);
		queue_cmd(MODE_POP_FRONT, 32'h0);
		queue_cmd(MODE_POP_BACK, 32'h0);
		queue_cmd(MODE_REVERSE, 32'h0);
		queue_cmd(MODE_POP_MIDDLE, 32'haaaa_aaaa);
		queue_cmd(MODE_POP_BACK, 32'h0);
		queue_cmd(MODE_POP_FRONT, 32'h0);
		// middle ops on an empty queue and on a single word
		queue_cmd(MODE_POP_MIDDLE, 32'h0);
		queue_cmd(MODE_PUSH_MIDDLE, 32'haaaa_aaaa);
		queue_cmd(MODE_POP_MIDDLE, 32'h0);
		queue_cmd(MODE_UNUSED, 32'h5555_5555);

		// random segments: filling ones hit the full case, draining ones empty
		while (cmd_backlog.size() < ITEM_TARGET + 23) begin
			roll = $urandom_range(0, 2);
			fill_bias = (roll == 0) ? 85 : (roll == 1) ? 50 : 20;
			seg_len = $urandom_range(10, 60);
			repeat (seg_len) begin
				val = ($urandom_range(0, 7) == 0) ? edge_vals[$urandom_range(0, 4)]
					: $urandom;
				roll = $urandom_range(0, 99);
				if (roll < 2)
					queue_cmd(MODE_UNUSED, val);
				else if (roll < 9)
					queue_cmd(MODE_REVERSE, val);
				else if ($urandom_range(0, 99) < fill_bias)
					queue_cmd(3'(MODE_PUSH_FRONT) + 3'($urandom_range(0, 2)), val);
				else
					queue_cmd(3'(MODE_POP_FRONT) + 3'($urandom_range(0, 2)), val);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// every word offered and taken, then every result back
		while (cmd_backlog.size() > 0) @(posedge clk);
		while (pending_results.size() > 0) @(posedge clk);
		// then wait on to catch a stray strobe
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
